### rtl/cu_pkg.sv
// ----------------------------------------------------------------------------
// cu_pkg: shared types and constants for the composition unranker
// Holds the size constants, the configuration bundle, the sequencer states
// and the binomial weight table built with the Pascal rule at elaboration.
// ----------------------------------------------------------------------------
package cu_pkg;

  localparam int MAX_TOTAL      = 15;
  localparam int MAX_CATEGORIES = 8;

  localparam int RANK_W   = 32;
  localparam int WEIGHT_W = RANK_W + 1;
  localparam int REG_W    = 4;
  localparam int COUNT_W  = 4;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int TOT_W  = $clog2(MAX_TOTAL + 1);
  localparam int PART_W = ($clog2(MAX_CATEGORIES) > INDEX_W) ? $clog2(MAX_CATEGORIES)
                                                            : INDEX_W;
  localparam int NROWS  = MAX_TOTAL + MAX_CATEGORIES;
  localparam int NCOLS  = MAX_CATEGORIES;
  localparam int ROW_W  = ($clog2(NROWS) > 0) ? $clog2(NROWS) : 1;
  localparam int COL_W  = ($clog2(NCOLS) > 0) ? $clog2(NCOLS) : 1;

  localparam logic [REG_W-1:0] TOTAL_RESET = REG_W'(2);
  localparam logic [REG_W-1:0] CATS_RESET  = REG_W'(2);

  // Weights at or above 2**32 all compare the same against a 32-bit rank.
  localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = {1'b1, {RANK_W{1'b0}}};

  typedef enum logic {
    REG_TOTAL = 1'b0,
    REG_CATS  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [TOT_W-1:0]  total;
    logic [PART_W-1:0] last_idx;
  } cfg_t;

  typedef logic [NROWS-1:0][NCOLS-1:0][WEIGHT_W-1:0] binom_tab_t;

  function automatic binom_tab_t build_binom();
    binom_tab_t        t;
    logic [WEIGHT_W:0] s;
    t = '0;
    for (int n = 0; n < NROWS; n++) begin
      for (int k = 0; k < NCOLS; k++) begin
        if (k > n) begin
          t[n][k] = '0;
        end else if (k == 0 || k == n) begin
          t[n][k] = WEIGHT_W'(1);
        end else begin
          s = {1'b0, t[n-1][k-1]} + {1'b0, t[n-1][k]};
          t[n][k] = (s > {1'b0, WEIGHT_SAT}) ? WEIGHT_SAT : s[WEIGHT_W-1:0];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

endpackage

### rtl/cu_regs.sv
// ----------------------------------------------------------------------------
// cu_regs: configuration registers of the composition unranker
// APB-style register file for the total and the number of categories, with
// the clamping of both to the supported range.
// ----------------------------------------------------------------------------
module cu_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cu_pkg::ADDR_W-1:0]  paddr,
  input  logic [cu_pkg::DATA_W-1:0]  pwdata,
  output logic [cu_pkg::DATA_W-1:0]  prdata,
  output logic                       pready,
  output cu_pkg::cfg_t               cfg
);

  logic [cu_pkg::REG_W-1:0] total_r, total_nxt;
  logic [cu_pkg::REG_W-1:0] cats_r, cats_nxt;
  cu_pkg::reg_idx_t         reg_idx;
  logic                     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cu_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    total_nxt = total_r;
    cats_nxt  = cats_r;
    if (wr_en) begin
      unique case (reg_idx)
        cu_pkg::REG_TOTAL: total_nxt = pwdata[cu_pkg::REG_W-1:0];
        cu_pkg::REG_CATS:  cats_nxt  = pwdata[cu_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= cu_pkg::TOTAL_RESET;
      cats_r  <= cu_pkg::CATS_RESET;
    end else begin
      total_r <= total_nxt;
      cats_r  <= cats_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      cu_pkg::REG_TOTAL: prdata = cu_pkg::DATA_W'(total_r);
      cu_pkg::REG_CATS:  prdata = cu_pkg::DATA_W'(cats_r);
      default:           prdata = '0;
    endcase
  end

  // A zero category count behaves as one category.
  always_comb begin
    if (32'(total_r) > cu_pkg::MAX_TOTAL) begin
      cfg.total = cu_pkg::TOT_W'(cu_pkg::MAX_TOTAL);
    end else begin
      cfg.total = cu_pkg::TOT_W'(total_r);
    end
    if (cats_r == '0) begin
      cfg.last_idx = '0;
    end else if (32'(cats_r) > cu_pkg::MAX_CATEGORIES) begin
      cfg.last_idx = cu_pkg::PART_W'(cu_pkg::MAX_CATEGORIES - 1);
    end else begin
      cfg.last_idx = cu_pkg::PART_W'(cats_r - 1'b1);
    end
  end

endmodule

### rtl/composition_unrank.sv
// ----------------------------------------------------------------------------
// composition_unrank: rank to weak composition decoder
// Splits the configured total over the configured categories by walking the
// rank down with binomial weights, one subtract-compare step per cycle.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     start, busy, in_rank_value              start & !busy
//  result    out_valid, out_category_index,          out_valid, one cycle
//            out_part_count, out_last_part,
//            out_range_error
//  config    psel, penable, pwrite, paddr, pwdata,    psel & penable, pready = 1
//            prdata, pready
//
// One shared 33-bit subtractor does every rank compare and every rank subtraction.
// Each part except the last takes a step per unit counted and one more step
// that emits its result, and the last part a single step that emits its
// result; an out-of-range rank ends early with one error result. Each result
// is registered and shows in the cycle after its step; the next transaction
// can be taken in the cycle the final result shows.
// Reset is synchronous and active low; there is no clearing pass. The
// receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module composition_unrank (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cu_pkg::RANK_W-1:0]    in_rank_value,
  output logic                         out_valid,
  output logic [cu_pkg::INDEX_W-1:0]   out_category_index,
  output logic [cu_pkg::COUNT_W-1:0]   out_part_count,
  output logic                         out_last_part,
  output logic                         out_range_error,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cu_pkg::ADDR_W-1:0]    paddr,
  input  logic [cu_pkg::DATA_W-1:0]    pwdata,
  output logic [cu_pkg::DATA_W-1:0]    prdata,
  output logic                         pready
);

  cu_pkg::cfg_t   cfg;
  cu_pkg::state_t state_r, state_nxt;

  logic [cu_pkg::RANK_W-1:0]  rank_r, rank_nxt;
  logic [cu_pkg::TOT_W-1:0]   left_r, left_nxt;
  logic [cu_pkg::TOT_W-1:0]   cnt_r, cnt_nxt;
  logic [cu_pkg::PART_W-1:0]  part_r, part_nxt;

  logic                        valid_r, valid_nxt;
  logic [cu_pkg::INDEX_W-1:0]  index_r, index_nxt;
  logic [cu_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                        last_r, last_nxt;
  logic                        err_r, err_nxt;

  logic [cu_pkg::PART_W-1:0]   m;
  logic [cu_pkg::TOT_W-1:0]    rest;
  logic [cu_pkg::ROW_W-1:0]    row;
  logic [cu_pkg::COL_W-1:0]    col;
  logic [cu_pkg::WEIGHT_W-1:0] weight;
  logic [cu_pkg::WEIGHT_W-1:0] diff;
  logic                        at_last;
  logic                        zero_left;
  logic                        fits;
  logic                        full;
  logic                        take;

  cu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign take = start & ~busy;
  assign busy = (state_r == cu_pkg::ST_SCAN);

  // Weight lookup and the shared subtractor; the borrow says rank < weight.
  assign m         = cfg.last_idx - part_r;
  assign rest      = left_r - cnt_r;
  assign row       = cu_pkg::ROW_W'(rest) + cu_pkg::ROW_W'(m);
  assign col       = m[cu_pkg::COL_W-1:0];
  assign weight    = cu_pkg::BINOM[row][col];
  assign diff      = {1'b0, rank_r} - weight;
  assign fits      = diff[cu_pkg::RANK_W];
  assign at_last   = (part_r == cfg.last_idx);
  assign zero_left = (left_r == '0);
  assign full      = (cnt_r == left_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cu_pkg::ST_IDLE: begin
        if (take) state_nxt = cu_pkg::ST_SCAN;
      end
      cu_pkg::ST_SCAN: begin
        if (at_last || (!zero_left && !fits && full)) state_nxt = cu_pkg::ST_IDLE;
      end
      default: state_nxt = cu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rank_nxt  = rank_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    part_nxt  = part_r;
    valid_nxt = 1'b0;
    index_nxt = index_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    unique case (state_r)
      cu_pkg::ST_IDLE: begin
        if (take) begin
          rank_nxt = in_rank_value;
          left_nxt = cfg.total;
          cnt_nxt  = '0;
          part_nxt = '0;
        end
      end
      cu_pkg::ST_SCAN: begin
        if (at_last) begin
          // The last part takes whatever is left.
          valid_nxt = 1'b1;
          index_nxt = part_r[cu_pkg::INDEX_W-1:0];
          count_nxt = cu_pkg::COUNT_W'(left_r);
          last_nxt  = 1'b1;
          err_nxt   = 1'b0;
        end else if (zero_left || fits) begin
          valid_nxt = 1'b1;
          index_nxt = part_r[cu_pkg::INDEX_W-1:0];
          count_nxt = cu_pkg::COUNT_W'(cnt_r);
          last_nxt  = 1'b0;
          err_nxt   = 1'b0;
          left_nxt  = rest;
          cnt_nxt   = '0;
          part_nxt  = part_r + 1'b1;
        end else if (full) begin
          // The rank is still at least the weight with nothing left to place.
          valid_nxt = 1'b1;
          index_nxt = part_r[cu_pkg::INDEX_W-1:0];
          count_nxt = '0;
          last_nxt  = 1'b1;
          err_nxt   = 1'b1;
        end else begin
          rank_nxt = diff[cu_pkg::RANK_W-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cu_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r  <= rank_nxt;
    left_r  <= left_nxt;
    cnt_r   <= cnt_nxt;
    part_r  <= part_nxt;
    index_r <= index_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
    err_r   <= err_nxt;
  end

  assign out_valid          = valid_r;
  assign out_category_index = index_r;
  assign out_part_count     = count_r;
  assign out_last_part      = last_r;
  assign out_range_error    = err_r;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_last_part)
    else $error("range error result not marked as last");

  a_end_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last_part)
    else $error("decode ended without a final result");

  a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not start decoding");

  a_idle_no_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_part |-> busy)
    else $error("intermediate result while idle");
`endif

endmodule
